/* rtl/core/sipq_pkg.sv */
// ============================================================================
// sipq_pkg
// Shared types and constants for the sorted-insert priority queue.
// ============================================================================
`default_nettype none

package sipq_pkg;

    // Queue geometry
    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 40;
    localparam int TAG_BITS   = 16;
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int OP_BITS    = 2;
    localparam int ST_BITS    = 2;
    localparam int OCC_BITS   = 5;

    // Beat layouts, padded to whole bytes
    localparam int IN_RAW_BITS  = OP_BITS + KEY_BITS + TAG_BITS;
    localparam int IN_BITS      = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS = ST_BITS + KEY_BITS + TAG_BITS + OCC_BITS;
    localparam int OUT_BITS     = ((OUT_RAW_BITS + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

    // Status codes
    localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [ST_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_BITS-1:0] ST_FULL  = 2'd2;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the input beat
        logic commit;  // update the cells and load the result register
    } t_dp_cmd;

endpackage

`default_nettype wire

/* rtl/core/sipq_datapath.sv */
// ============================================================================
// sipq_datapath
// Sorted cell array with per-cell compare, shift logic and result register.
// ============================================================================
`default_nettype none

module sipq_datapath
    import sipq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic [OP_BITS-1:0]  i_opcode,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire logic [TAG_BITS-1:0] i_tag,
    output logic [ST_BITS-1:0]       o_status,
    output logic [KEY_BITS-1:0]      o_popped_key,
    output logic [TAG_BITS-1:0]      o_popped_tag,
    output logic [OCC_BITS-1:0]      o_occupancy
);

    // Captured request
    logic [OP_BITS-1:0]  r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;

    // Cells, head at index 0
    logic [KEY_BITS-1:0] r_cell_key [DEPTH];
    logic [TAG_BITS-1:0] r_cell_tag [DEPTH];
    logic [KEY_BITS-1:0] n_cell_key [DEPTH];
    logic [TAG_BITS-1:0] n_cell_tag [DEPTH];
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;

    // Result register
    logic [ST_BITS-1:0]  r_status;
    logic [KEY_BITS-1:0] r_pkey;
    logic [TAG_BITS-1:0] r_ptag;
    logic [OCC_BITS-1:0] r_occ;
    logic [ST_BITS-1:0]  n_status;
    logic [KEY_BITS-1:0] n_pkey;
    logic [TAG_BITS-1:0] n_ptag;

    logic [DEPTH-1:0] move;
    logic             empty;
    logic             full;
    logic             below_head;

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_key <= i_key;
            r_tag <= i_tag;
        end
    end

    assign empty      = (r_count == '0);
    assign full       = (r_count == CNT_BITS'(DEPTH));
    assign below_head = (r_key < r_cell_key[0]);

    // Mark cells at or past the insert point; the list is nondecreasing, so the mark
    // is a run from the insert point up to the last cell
    always_comb begin
        move[0] = empty || below_head;
        for (int i = 1; i < DEPTH; i++) begin
            move[i] = below_head || (CNT_BITS'(i) >= r_count) || (r_cell_key[i] >= r_key);
        end
    end

    // Next cell contents per operation
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_pkey   = '0;
        n_ptag   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            n_cell_key[i] = r_cell_key[i];
            n_cell_tag[i] = r_cell_tag[i];
        end
        case (r_op)
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    // Head cell takes the new entry or holds
                    if (move[0]) begin
                        n_cell_key[0] = r_key;
                        n_cell_tag[0] = r_tag;
                    end
                    // Other cells: new entry at the edge, shift up past it
                    for (int i = 1; i < DEPTH; i++) begin
                        if (move[i] && !move[i-1]) begin
                            n_cell_key[i] = r_key;
                            n_cell_tag[i] = r_tag;
                        end else if (move[i]) begin
                            n_cell_key[i] = r_cell_key[i-1];
                            n_cell_tag[i] = r_cell_tag[i-1];
                        end
                    end
                end
            end
            OP_REMOVE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    n_pkey  = r_cell_key[0];
                    n_ptag  = r_cell_tag[0];
                    // Advance each cell but the last toward the head
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        n_cell_key[i] = r_cell_key[i+1];
                        n_cell_tag[i] = r_cell_tag[i+1];
                    end
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Commit cells and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_cell_key[i] <= n_cell_key[i];
                r_cell_tag[i] <= n_cell_tag[i];
            end
            r_status <= n_status;
            r_pkey   <= n_pkey;
            r_ptag   <= n_ptag;
            r_occ    <= OCC_BITS'(n_count);
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    assign o_status     = r_status;
    assign o_popped_key = r_pkey;
    assign o_popped_tag = r_ptag;
    assign o_occupancy  = r_occ;

endmodule

`default_nettype wire

/* rtl/core/sipq_ctrl.sv */
// ============================================================================
// sipq_ctrl
// Request sequencer and result-valid tracking for the priority queue.
// ============================================================================
`default_nettype none

module sipq_ctrl
    import sipq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_dp_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // Commit once the result register is free or draining
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/core/sorted_insert_priority_queue_unit.sv */
// ============================================================================
// sorted_insert_priority_queue_unit
// Bounded priority queue held in ascending key order in a row of cells.
// ============================================================================
// Each request beat (insert, remove head, clear) returns one result beat with
// a status, the popped entry on a successful remove, and the occupancy after
// the operation. The unit captures the beat in its idle state, then in its
// execute state all cells compare against the key in parallel and shift in place;
// the next request is taken in the cycle after that, so a request is not accepted
// while the previous one executes. The result sits in an output register, so a new
// request is accepted while a result waits; a result still unclaimed when the
// next one is ready holds the unit in its execute state until the sink takes it.
// Equal keys are placed ahead of existing equal entries, except that a key
// equal to the head goes directly after the head.
`default_nettype none

module sorted_insert_priority_queue_unit
    import sipq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [IN_BITS-1:0]  s_axis_tdata,  // opcode, key, tag, zero pad
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [OUT_BITS-1:0]      m_axis_tdata   // status, popped_key, popped_tag,
                                                    // occupancy, zero pad
);

    t_dp_cmd             cmd;
    logic [ST_BITS-1:0]  status;
    logic [KEY_BITS-1:0] popped_key;
    logic [TAG_BITS-1:0] popped_tag;
    logic [OCC_BITS-1:0] occupancy;

    sipq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    sipq_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (s_axis_tdata[OP_BITS-1:0]),
        .i_key        (s_axis_tdata[OP_BITS +: KEY_BITS]),
        .i_tag        (s_axis_tdata[OP_BITS+KEY_BITS +: TAG_BITS]),
        .o_status     (status),
        .o_popped_key (popped_key),
        .o_popped_tag (popped_tag),
        .o_occupancy  (occupancy)
    );

    // Pack the result beat
    assign m_axis_tdata = OUT_BITS'({occupancy, popped_tag, popped_key, status});

endmodule

`default_nettype wire

/* rtl/core/sipq_checker.sv */
// ============================================================================
// sipq_checker
// Port-level checks for the priority queue, bound to the top level.
// ============================================================================
`default_nettype none

module sipq_checker
    import sipq_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [OUT_BITS-1:0] m_axis_tdata
);

    logic [ST_BITS-1:0]  st;
    logic [OCC_BITS-1:0] occ;
    logic [KEY_BITS-1:0] pkey;

    assign st   = m_axis_tdata[ST_BITS-1:0];
    assign pkey = m_axis_tdata[ST_BITS +: KEY_BITS];
    assign occ  = m_axis_tdata[ST_BITS+KEY_BITS+TAG_BITS +: OCC_BITS];

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // Occupancy never exceeds the queue depth
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> occ <= OCC_BITS'(DEPTH))
        else $error("occupancy beyond depth");

    // Remove on empty leaves nothing and pops zero
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st == ST_EMPTY |-> occ == '0 && pkey == '0)
        else $error("empty remove reported entries");

    // Full refusal reports a full queue
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && st == ST_FULL |-> occ == OCC_BITS'(DEPTH))
        else $error("insert refused while not full");

    // No request taken in the cycle right after one is taken
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted during execute");

endmodule

bind sorted_insert_priority_queue_unit sipq_checker u_sipq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* bench/tb.sv */
// ============================================================================
// tb
// Self-checking bench for the sorted-insert priority queue unit.
// ============================================================================
// A shadow copy of the sorted list predicts the status, popped entry and
// occupancy of every request beat. Each result beat is checked, field by
// field, against the oldest prediction. The stimulus runs a short directed
// pass over the corner cases, then random fill and drain traffic, a
// back-to-back burst, a long sink hold-off, and a mixed tail. Both sides of
// the stream idle at random.

module tb;
    import sipq_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED   = 2'd3;
    localparam int                 DRAIN_WAIT  = 8;
    localparam int                 STALL_LIMIT = 2000;
    localparam int                 HOLDOFF_LEN = 150;

    typedef struct packed {
        logic [OP_BITS-1:0]  op;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_request;

    typedef struct packed {
        logic [ST_BITS-1:0]  status;
        logic [KEY_BITS-1:0] popped_key;
        logic [TAG_BITS-1:0] popped_tag;
        logic [OCC_BITS-1:0] occupancy;
    } t_outcome;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata  = '0;  // opcode, key, tag, zero pad
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;        // status, popped_key, popped_tag,
                                              // occupancy, zero pad

    // Shadow copy of the sorted list
    logic [KEY_BITS-1:0] shadow_keys [DEPTH];
    logic [TAG_BITS-1:0] shadow_tags [DEPTH];
    int                  shadow_count = 0;

    t_outcome pending_outcomes [$];
    int       mismatch_count = 0;
    int       beats_checked  = 0;
    int       send_gap_pct   = 18;
    int       sink_stall_pct = 18;
    int       holdoff_req    = 0;
    int       holdoff_left   = 0;
    int       quiet_cycles   = 0;

    sorted_insert_priority_queue_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Predict one request and advance the shadow list
    function automatic t_outcome apply_queue_op(t_request req);
        t_outcome res;
        int       pos;
        logic     found;
        res = '0;
        res.status = ST_OK;
        case (req.op)
            OP_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = shadow_count;
                    found = 1'b0;
                    if (shadow_count == 0 || req.key < shadow_keys[0]) begin
                        pos = 0;
                    end else begin
                        for (int i = 1; i < shadow_count; i++) begin
                            if (!found && shadow_keys[i] >= req.key) begin
                                pos = i;
                                found = 1'b1;
                            end
                        end
                    end
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_tags[i] = shadow_tags[i-1];
                    end
                    shadow_keys[pos] = req.key;
                    shadow_tags[pos] = req.tag;
                    shadow_count++;
                end
            end
            OP_REMOVE: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped_key = shadow_keys[0];
                    res.popped_tag = shadow_tags[0];
                    for (int i = 1; i < shadow_count; i++) begin
                        shadow_keys[i-1] = shadow_keys[i];
                        shadow_tags[i-1] = shadow_tags[i];
                    end
                    shadow_count--;
                end
            end
            OP_CLEAR: begin
                shadow_count = 0;
            end
            default: ;
        endcase
        res.occupancy = shadow_count[OCC_BITS-1:0];
        return res;
    endfunction

    // Offer one request beat, with a random gap ahead of it
    task automatic send_request(input logic [OP_BITS-1:0] op,
                                input logic [KEY_BITS-1:0] key,
                                input logic [TAG_BITS-1:0] tag);
        t_request req;
        req.op  = op;
        req.key = key;
        req.tag = tag;
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_BITS-IN_RAW_BITS){1'b0}}, tag, key, op};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        pending_outcomes.push_back(apply_queue_op(req));
    endtask

    // Hold the source until every predicted beat has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR: result beat %0d %s: got 0x%0h, want 0x%0h",
                 beats_checked, field, got, want);
        mismatch_count++;
    endtask

    // Key drawn from BCD digits, a small pool that forces ties, or raw bits
    function automatic logic [KEY_BITS-1:0] random_key();
        logic [KEY_BITS-1:0] k;
        k = '0;
        case ($urandom_range(3))
            0: begin
                for (int d = 0; d < KEY_BITS / 4; d++) begin
                    k = {k[KEY_BITS-5:0], 4'($urandom_range(9))};
                end
            end
            1: k = KEY_BITS'($urandom_range(5)) * 40'h11_1111_1111;
            2: k = KEY_BITS'({$urandom, $urandom});
            default: k = KEY_BITS'($urandom_range(7));
        endcase
        return k;
    endfunction

    task automatic send_random(input int insert_pct);
        logic [OP_BITS-1:0] op;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 3) begin
            op = OP_CLEAR;
        end else if (pick < 6) begin
            op = OP_UNUSED;
        end else if (pick < 6 + (insert_pct * 94) / 100) begin
            op = OP_INSERT;
        end else begin
            op = OP_REMOVE;
        end
        send_request(op, random_key(), TAG_BITS'($urandom));
    endtask

    // Corner cases: empty, unused opcode, ties, extremes, full
    task automatic test_special_cases();
        send_request(OP_REMOVE, '0, '0);
        send_request(OP_UNUSED, '1, '1);
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_INSERT, 40'h00_0000_0500, 16'h0001);
        send_request(OP_INSERT, 40'h00_0000_0500, 16'h0002);
        send_request(OP_INSERT, 40'h99_9999_9999, 16'hFFFF);
        send_request(OP_INSERT, 40'hFF_FFFF_FFFF, 16'h0000);
        send_request(OP_INSERT, 40'h00_0000_0000, 16'h1234);
        send_request(OP_INSERT, 40'h00_0000_0500, 16'h0003);
        send_request(OP_INSERT, 40'h00_0000_0000, 16'h0004);
        repeat (DEPTH - 7) send_request(OP_INSERT, random_key(), TAG_BITS'($urandom));
        send_request(OP_INSERT, 40'h00_0000_0001, 16'hBEEF);
        send_request(OP_UNUSED, '0, '0);
        send_request(OP_REMOVE, '0, '0);
        send_request(OP_CLEAR, '0, '0);
    endtask

    // Alternate fill-heavy and drain-heavy stretches
    task automatic test_fill_and_drain();
        repeat (4) begin
            repeat (40) send_random(80);
            repeat (40) send_random(25);
        end
    endtask

    // Back-to-back beats on both sides
    task automatic test_back_to_back();
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        repeat (100) send_random(55);
        send_gap_pct   = 18;
        sink_stall_pct = 18;
    endtask

    // Hold off the sink while the source keeps offering beats
    task automatic test_sink_holdoff();
        send_gap_pct = 0;
        holdoff_req  = HOLDOFF_LEN;
        repeat (30) send_random(60);
        send_gap_pct = 18;
    endtask

    task automatic test_mixed_traffic();
        repeat (150) send_random(50);
    endtask

    // Drive the sink ready: random stalls, or a long counted hold-off
    always @(posedge i_clk) begin
        if (holdoff_req != 0) begin
            holdoff_left = holdoff_req;
            holdoff_req  = 0;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Check each result beat against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_outcome got;
        t_outcome want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got.status     = m_axis_tdata[1:0];
            got.popped_key = m_axis_tdata[41:2];
            got.popped_tag = m_axis_tdata[57:42];
            got.occupancy  = m_axis_tdata[62:58];
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, '0);
            end else begin
                want = pending_outcomes.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.popped_key !== want.popped_key)
                    report_mismatch("popped_key", 64'(got.popped_key),
                                    64'(want.popped_key));
                if (got.popped_tag !== want.popped_tag)
                    report_mismatch("popped_tag", 64'(got.popped_tag),
                                    64'(want.popped_tag));
                if (got.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 64'(got.occupancy),
                                    64'(want.occupancy));
                if (m_axis_tdata[OUT_BITS-1:OUT_RAW_BITS] !== '0)
                    report_mismatch("pad", 64'(m_axis_tdata[OUT_BITS-1:OUT_RAW_BITS]), '0);
            end
            beats_checked++;
        end
    end

    // Abort when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_cases();
        wait_for_results();
        test_fill_and_drain();
        test_back_to_back();
        test_sink_holdoff();
        wait_for_results();
        test_mixed_traffic();
        wait_for_results();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
